>>> design/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg
// shared constants, types and byte functions of the aes-128 encryption block
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned RoundW    = 4;

  localparam logic [1:0] CfgKeyLow  = 2'd0;
  localparam logic [1:0] CfgKeyHigh = 2'd1;

  localparam logic [7:0] SboxTab [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // command from controller to datapath
  typedef struct packed {
    logic              load;      // take plaintext, add round key 0
    logic              round;     // run one cipher round
    logic              last;      // round without mixcolumns
    logic [RoundW-1:0] rnd;       // round key index
    logic              key_init;  // restart key schedule from the cipher key
    logic              key_step;  // derive next round key
  } aes_cmd_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [RoundW-1:0] r);
    case (r)
      4'd1:    rcon = 8'h01;
      4'd2:    rcon = 8'h02;
      4'd3:    rcon = 8'h04;
      4'd4:    rcon = 8'h08;
      4'd5:    rcon = 8'h10;
      4'd6:    rcon = 8'h20;
      4'd7:    rcon = 8'h40;
      4'd8:    rcon = 8'h80;
      4'd9:    rcon = 8'h1b;
      4'd10:   rcon = 8'h36;
      default: rcon = 8'h00;
    endcase
  endfunction

endpackage

>>> design/aes_datapath.sv
// ----------------------------------------------------------------------------
// aes_datapath
// state register, shared round unit and round key store with key schedule
// ----------------------------------------------------------------------------
module aes_datapath (
  input  logic              clk_i,
  input  aes_pkg::aes_cmd_t cmd_i,
  input  logic [127:0]      key_i,
  input  logic [127:0]      block_i,
  output logic [127:0]      state_o
);

  logic [127:0] state_q, state_d;
  logic [127:0] rk_mem [11];
  logic [127:0] kcur_q, kcur_d;
  logic [127:0] rk_q;
  logic [127:0] sr, mc;
  logic [31:0]  tw;
  logic [7:0]   a0, a1, a2, a3, al;

  function automatic logic [7:0] SubW(input logic [7:0] b);
    SubW = aes_pkg::SboxTab[b];
  endfunction

  // round key read, registered; index is presented in the cycle before the key is used
  always_ff @(posedge clk_i) begin
    rk_q <= rk_mem[cmd_i.rnd];
  end

  // key schedule, one round key per step
  always_comb begin
    tw = {SubW(kcur_q[103:96]), SubW(kcur_q[127:120]), SubW(kcur_q[119:112]),
          SubW(kcur_q[111:104]) ^ aes_pkg::rcon(cmd_i.rnd)};
    kcur_d[31:0]   = kcur_q[31:0] ^ tw;
    kcur_d[63:32]  = kcur_q[63:32] ^ kcur_d[31:0];
    kcur_d[95:64]  = kcur_q[95:64] ^ kcur_d[63:32];
    kcur_d[127:96] = kcur_q[127:96] ^ kcur_d[95:64];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_init) begin
      kcur_q    <= key_i;
      rk_mem[0] <= key_i;
    end else if (cmd_i.key_step) begin
      kcur_q             <= kcur_d;
      rk_mem[cmd_i.rnd]  <= kcur_d;
    end
  end

  // subbytes and shiftrows, then mixcolumns
  always_comb begin
    sr = '0;
    mc = '0;
    a0 = '0; a1 = '0; a2 = '0; a3 = '0; al = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[(c*4+r)*8 +: 8] = aes_pkg::SboxTab[state_q[((((c+r)%4)*4)+r)*8 +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sr[(c*4)*8 +: 8];
      a1 = sr[(c*4+1)*8 +: 8];
      a2 = sr[(c*4+2)*8 +: 8];
      a3 = sr[(c*4+3)*8 +: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[(c*4)*8 +: 8]   = a0 ^ al ^ aes_pkg::xtime(a0 ^ a1);
      mc[(c*4+1)*8 +: 8] = a1 ^ al ^ aes_pkg::xtime(a1 ^ a2);
      mc[(c*4+2)*8 +: 8] = a2 ^ al ^ aes_pkg::xtime(a2 ^ a3);
      mc[(c*4+3)*8 +: 8] = a3 ^ al ^ aes_pkg::xtime(a3 ^ a0);
    end
  end

  always_comb begin
    state_d = state_q;
    if (cmd_i.load) begin
      state_d = block_i ^ rk_q;
    end else if (cmd_i.round) begin
      state_d = (cmd_i.last ? sr : mc) ^ rk_q;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
  end

  assign state_o = state_q;

endmodule

>>> design/aes_ctrl.sv
// ----------------------------------------------------------------------------
// aes_ctrl
// sequencer for key expansion, rounds and the output register handshake
// ----------------------------------------------------------------------------
module aes_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              key_wr_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              out_load_o,
  output aes_pkg::aes_cmd_t cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StKexp  = 3'd1;
  localparam logic [2:0] StLoad  = 3'd2;
  localparam logic [2:0] StRound = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  logic [2:0] st_q, st_d;
  logic [aes_pkg::RoundW-1:0] rnd_q, rnd_d;
  logic ov_q, ov_d;
  logic kpend_q, kpend_d;
  logic accept, out_take;

  assign out_take    = ov_q & ~out_stall_i;
  assign in_stall_o  = (st_q != StIdle) | kpend_q | key_wr_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_o = ov_q;

  always_comb begin
    st_d       = st_q;
    rnd_d      = rnd_q;
    ov_d       = ov_q & ~out_take;
    kpend_d    = kpend_q | key_wr_i;
    out_load_o = 1'b0;
    cmd_o      = '0;
    cmd_o.rnd  = rnd_q;
    case (st_q)
      StIdle: begin
        if (kpend_q) begin
          cmd_o.key_init = 1'b1;
          kpend_d        = key_wr_i;
          rnd_d          = 4'd1;
          st_d           = StKexp;
        end else if (accept) begin
          cmd_o.rnd = '0;
          rnd_d     = 4'd1;
          st_d      = StLoad;
        end
      end
      StKexp: begin
        cmd_o.key_step = 1'b1;
        rnd_d          = rnd_q + 4'd1;
        if (rnd_q == 4'(aes_pkg::NumRounds)) begin
          st_d = StIdle;
        end
      end
      StLoad: begin
        cmd_o.load = 1'b1;
        rnd_d      = rnd_q + 4'd1;
        st_d       = StRound;
      end
      StRound: begin
        cmd_o.round = 1'b1;
        cmd_o.last  = (rnd_q == 4'(aes_pkg::NumRounds + 1));
        rnd_d       = rnd_q + 4'd1;
        if (cmd_o.last) begin
          st_d = StDone;
        end
      end
      StDone: begin
        if (!ov_q || out_take) begin
          out_load_o = 1'b1;
          ov_d       = 1'b1;
          st_d       = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      rnd_q   <= '0;
      ov_q    <= 1'b0;
      kpend_q <= 1'b1;
    end else begin
      st_q    <= st_d;
      rnd_q   <= rnd_d;
      ov_q    <= ov_d;
      kpend_q <= kpend_d;
    end
  end

endmodule

>>> design/aes128_block_encrypt.sv
// ----------------------------------------------------------------------------
// aes128_block_encrypt
// aes-128 forward cipher, one 16-byte block per request
// ----------------------------------------------------------------------------
// input channel: block_low_i/block_high_i with in_valid_i/in_stall_o.
// output channel: cipher_low_o/cipher_high_o with out_valid_o/out_stall_i.
// key: cfg_we_i, cfg_index_i (0 low half, 1 high half), cfg_wdata_i.
// a key write starts a re-expansion of the eleven round keys,
// one round key per cycle through the key schedule unit; requests stall
// meanwhile. reset expands the all-zero key the same way.
// a request passes these steps from acceptance to the output register:
// the round key read at acceptance, the initial key addition, ten
// rounds in the shared round unit, one round per cycle, and the output load.
// a new request is accepted only after the previous one reaches the output register.
// the output register holds the ciphertext while the receiver stalls; the
// next block may finish meanwhile and waits in the state register.
// ----------------------------------------------------------------------------
module aes128_block_encrypt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] block_low_i,
  input  logic [63:0] block_high_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] cipher_low_o,
  output logic [63:0] cipher_high_o
);

  logic [63:0]  key_lo_q, key_hi_q;
  logic [127:0] ct_q, state;
  logic         key_wr, out_load;
  aes_pkg::aes_cmd_t cmd;

  assign key_wr = cfg_we_i & ((cfg_index_i == aes_pkg::CfgKeyLow) |
                              (cfg_index_i == aes_pkg::CfgKeyHigh));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q <= '0;
      key_hi_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == aes_pkg::CfgKeyLow) key_lo_q <= cfg_wdata_i;
      if (cfg_index_i == aes_pkg::CfgKeyHigh) key_hi_q <= cfg_wdata_i;
    end
  end

  aes_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_wr_i    (key_wr),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_load_o  (out_load),
    .cmd_o       (cmd)
  );

  logic [127:0] blk_q;
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) blk_q <= {block_high_i, block_low_i};
  end

  aes_datapath u_dp (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .key_i   ({key_hi_q, key_lo_q}),
    .block_i (blk_q),
    .state_o (state)
  );

  always_ff @(posedge clk_i) begin
    if (out_load) ct_q <= state;
  end

  assign cipher_low_o  = ct_q[63:0];
  assign cipher_high_o = ct_q[127:64];

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while busy");
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.round && (cmd.key_step || cmd.key_init || cmd.load)))
    else $error("round overlaps key schedule");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(ct_q))
    else $error("output changed under stall");

endmodule

>>> sim/aes128_cipher_checker.sv
// ----------------------------------------------------------------------------
// aes128_cipher_checker
// watches both channels of the aes-128 block, computes the ciphertext of
// every accepted request from its own key schedule and compares results
// ----------------------------------------------------------------------------
module aes128_cipher_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [63:0] block_low_i,
  input  logic [63:0] block_high_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [63:0] cipher_low_i,
  input  logic [63:0] cipher_high_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          cipher_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0]  key_lo_q, key_hi_q;
  logic [127:0] round_keys [11];
  logic [127:0] cipher_q [$];

  function automatic logic [7:0] mul2(input logic [7:0] a);
    mul2 = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i in bits 8i+7:8i
  task automatic build_round_keys();
    logic [7:0] kb [176];
    logic [7:0] t [4];
    logic [7:0] x;
    logic [7:0] rc;
    logic [127:0] k;
    k = {key_hi_q, key_lo_q};
    for (int i = 0; i < 16; i++) kb[i] = k[8*i +: 8];
    rc = 8'h01;
    for (int w = 4; w < 44; w++) begin
      for (int j = 0; j < 4; j++) t[j] = kb[(w-1)*4 + j];
      if (w % 4 == 0) begin
        x = t[0];
        t[0] = aes_pkg::SboxTab[t[1]] ^ rc;
        t[1] = aes_pkg::SboxTab[t[2]];
        t[2] = aes_pkg::SboxTab[t[3]];
        t[3] = aes_pkg::SboxTab[x];
        rc = mul2(rc);
      end
      for (int j = 0; j < 4; j++) kb[w*4 + j] = kb[(w-4)*4 + j] ^ t[j];
    end
    for (int r = 0; r < 11; r++)
      for (int i = 0; i < 16; i++) round_keys[r][8*i +: 8] = kb[r*16 + i];
  endtask

  function automatic logic [127:0] encrypt_block(input logic [127:0] pt);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) s[i] = pt[8*i +: 8] ^ round_keys[0][8*i +: 8];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++)
          t[c*4 + w] = aes_pkg::SboxTab[s[((c + w) % 4)*4 + w]];
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          t[c*4]   = a0 ^ all ^ mul2(a0 ^ a1);
          t[c*4+1] = a1 ^ all ^ mul2(a1 ^ a2);
          t[c*4+2] = a2 ^ all ^ mul2(a2 ^ a3);
          t[c*4+3] = a3 ^ all ^ mul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ round_keys[r][8*i +: 8];
    end
    for (int i = 0; i < 16; i++) res[8*i +: 8] = s[i];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    cipher_count_o = 0;
    key_lo_q = '0;
    key_hi_q = '0;
    build_round_keys();
  end

  assign pending_o = cipher_q.size();

  always @(posedge clk_i) begin
    logic [127:0] want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        cipher_count_o++;
        if (cipher_q.size() == 0) begin
          report_mismatch("unexpected result", cipher_low_i, 64'h0);
        end else begin
          want = cipher_q.pop_front();
          if (cipher_low_i !== want[63:0])
            report_mismatch("cipher_low", cipher_low_i, want[63:0]);
          if (cipher_high_i !== want[127:64])
            report_mismatch("cipher_high", cipher_high_i, want[127:64]);
        end
      end
      if (in_valid_i && !in_stall_i)
        cipher_q.push_back(encrypt_block({block_high_i, block_low_i}));
      if (cfg_we_i) begin
        if (cfg_index_i == aes_pkg::CfgKeyLow) begin
          key_lo_q = cfg_wdata_i;
          build_round_keys();
        end else if (cfg_index_i == aes_pkg::CfgKeyHigh) begin
          key_hi_q = cfg_wdata_i;
          build_round_keys();
        end
      end
    end
  end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives key writes and plaintext requests into the aes-128 block with
// random gaps and output stalls; a checker predicts and compares ciphertext
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1200000;
  localparam logic [1:0] CfgUnused = 2'd2;
  localparam logic [1:0] CfgTop    = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = aes_pkg::CfgKeyLow;
  logic [63:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] block_low_i = '0;
  logic [63:0] block_high_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] cipher_low_o;
  logic [63:0] cipher_high_o;
  int          fail_count, pending, cipher_count;
  int          send_idle_pct, recv_idle_pct;
  int unsigned cycle_count = 0;
  int          key_writes = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  aes128_block_encrypt u_dut (.*);

  aes128_cipher_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .block_low_i, .block_high_i,
    .out_valid_i(out_valid_o), .out_stall_i, .cipher_low_i(cipher_low_o),
    .cipher_high_i(cipher_high_o), .fail_count_o(fail_count),
    .pending_o(pending), .cipher_count_o(cipher_count)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (recv_idle_pct > 0) out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    else out_stall_i <= 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // valid stays high after the request so that back-to-back requests
  // never assign it twice in one time step
  task automatic send_block(input logic [63:0] lo, input logic [63:0] hi);
    cfg_we_i <= 1'b0;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i   <= 1'b1;
    block_low_i  <= lo;
    block_high_i <= hi;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    while (pending > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_key(input logic [1:0] idx, input logic [63:0] val);
    in_valid_i  <= 1'b0;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    key_writes++;
  endtask

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset key, extremes of the block
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h8877665544332211, 64'h00ffeeddccbbaa99);
    drain();
    // fips-197 example key
    write_key(aes_pkg::CfgKeyLow, 64'h0706050403020100);
    write_key(aes_pkg::CfgKeyHigh, 64'h0f0e0d0c0b0a0908);
    send_block(64'h7766554433221100, 64'hffeeddccbbaa9988);
    send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    drain();
    // out of range indexes are ignored
    write_key(CfgUnused, '1);
    write_key(CfgTop, 64'h0123456789abcdef);
    send_block('0, '1);
    drain();
    // all-ones key, then one half changed
    write_key(aes_pkg::CfgKeyLow, '1);
    write_key(aes_pkg::CfgKeyHigh, '1);
    send_block('0, '0);
    send_block('1, '1);
    drain();
    write_key(aes_pkg::CfgKeyLow, '0);
    send_block('1, '0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 53 : 0;
      recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 38 : 0;
      for (int n = 0; n < 660; n++) begin
        if (n % 110 == 0) begin
          drain();
          write_key($urandom_range(1) ? aes_pkg::CfgKeyHigh : aes_pkg::CfgKeyLow,
                    rand64());
          if ($urandom_range(3) == 0) write_key(CfgUnused, rand64());
        end
        if (n == 330) drain();
        send_block(rand64(), rand64());
      end
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;

    drain();
    $display("%0d ciphertexts checked over %0d key writes", cipher_count, key_writes);
    $display("phases with sender gaps, receiver stalls and back-to-back traffic");
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
design/aes_pkg.sv
design/aes_datapath.sv
design/aes_ctrl.sv
design/aes128_block_encrypt.sv
sim/aes128_cipher_checker.sv
sim/testbench.sv
